### hw/rtl/button_click_press_detector_macros.svh
// Assertion macros for the button press detector checker.
// Expects clk and rst in scope of the module that uses them.
`ifndef BUTTON_CLICK_PRESS_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_PRESS_DETECTOR_MACROS_SVH

// same-cycle implication
`define BCPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bcpd_pkg.sv
// Types and constants shared by the button press detector.
// No dependencies.
package bcpd_pkg;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DOWN     = 3'd1,
    ST_UP       = 3'd2,
    ST_COUNT    = 3'd3,
    ST_PRESS    = 3'd4,
    ST_PRESSEND = 3'd5
  } fsm_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_CLICK   = 3'd1,
    EV_DOUBLE  = 3'd2,
    EV_MULTI   = 3'd3,
    EV_LSTART  = 3'd4,
    EV_LREPEAT = 3'd5,
    EV_LSTOP   = 3'd6
  } event_t;

  localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [2:0] REG_CLICK       = 3'd1;
  localparam logic [2:0] REG_PRESS       = 3'd2;
  localparam logic [2:0] REG_REPEAT      = 3'd3;
  localparam logic [2:0] REG_PRESSED_LVL = 3'd4;
  localparam logic [2:0] REG_CLICK_LIMIT = 3'd5;

  localparam logic [15:0] DEF_DEBOUNCE    = 16'd50;
  localparam logic [15:0] DEF_CLICK       = 16'd400;
  localparam logic [15:0] DEF_PRESS       = 16'd800;
  localparam logic [15:0] DEF_REPEAT      = 16'd3000;
  localparam logic        DEF_PRESSED_LVL = 1'b0;
  localparam logic [6:0]  DEF_CLICK_LIMIT = 7'd1;

  localparam logic [6:0]  CNT_MAX = 7'd127;

  typedef struct packed {
    logic [15:0] debounce_len;
    logic [15:0] click_gap;
    logic [15:0] hold_len;
    logic [15:0] repeat_ms;
    logic        pressed_level;
    logic [6:0]  click_limit;
  } cfg_t;

  typedef struct packed {
    fsm_t        fsm;
    logic [6:0]  count;
    logic [31:0] press_start;
    logic [31:0] repeat_time;
    logic [31:0] settle_time;
    logic        raw_known;
    logic        last_raw;
    logic        stable_known;
    logic        stable_level;
  } state_t;

  typedef struct packed {
    logic        raw_level;
    logic [31:0] now_ms;
    logic        clear;
  } poll_t;

  typedef struct packed {
    event_t      ev;
    logic [6:0]  click_count;
    logic        level_known;
    logic        debounced_level;
    logic        is_idle;
    logic        is_long_pressed;
    logic [31:0] pressed_ms;
  } result_t;

endpackage

### hw/rtl/bcpd_step.sv
// One poll step: debouncer and press state machine, next state and result.
// Depends on bcpd_pkg.
module bcpd_step (
  input  bcpd_pkg::cfg_t    cfg,
  input  bcpd_pkg::state_t  cur,
  input  bcpd_pkg::poll_t   poll,
  output bcpd_pkg::state_t  nxt,
  output bcpd_pkg::result_t res
);
  import bcpd_pkg::*;

  logic        active;
  logic [31:0] wait_ms;
  logic [31:0] settle_age;
  logic [31:0] repeat_age;
  event_t      ev;

  assign wait_ms    = poll.now_ms - cur.press_start;
  assign settle_age = poll.now_ms - cur.settle_time;
  assign repeat_age = poll.now_ms - cur.repeat_time;

  always_comb begin
    nxt    = cur;
    ev     = EV_NONE;
    active = 1'b0;
    if (poll.clear) begin
      nxt.fsm         = ST_IDLE;
      nxt.count       = 7'd0;
      nxt.press_start = 32'd0;
    end else begin
      if (cur.raw_known && (cur.last_raw == poll.raw_level)) begin
        if (settle_age >= 32'(cfg.debounce_len)) begin
          nxt.stable_known = 1'b1;
          nxt.stable_level = poll.raw_level;
        end
      end else begin
        nxt.settle_time = poll.now_ms;
        nxt.last_raw    = poll.raw_level;
        nxt.raw_known   = 1'b1;
      end
      active = nxt.stable_known && (nxt.stable_level == cfg.pressed_level);

      case (cur.fsm)
        ST_IDLE: begin
          if (active) begin
            nxt.fsm         = ST_DOWN;
            nxt.press_start = poll.now_ms;
            nxt.count       = 7'd0;
          end
        end
        ST_DOWN: begin
          if (!active) begin
            nxt.fsm         = ST_UP;
            nxt.press_start = poll.now_ms;
          end else if (wait_ms > 32'(cfg.hold_len)) begin
            ev      = EV_LSTART;
            nxt.fsm = ST_PRESS;
          end
        end
        ST_UP: begin
          if (cur.count != CNT_MAX) begin
            nxt.count = cur.count + 7'd1;
          end
          nxt.fsm = ST_COUNT;
        end
        ST_COUNT: begin
          if (active) begin
            nxt.fsm         = ST_DOWN;
            nxt.press_start = poll.now_ms;
          end else if ((wait_ms >= 32'(cfg.click_gap)) ||
                       (cur.count == cfg.click_limit)) begin
            if (cur.count == 7'd1) begin
              ev = EV_CLICK;
            end else if (cur.count == 7'd2) begin
              ev = EV_DOUBLE;
            end else begin
              ev = EV_MULTI;
            end
            nxt.fsm         = ST_IDLE;
            nxt.count       = 7'd0;
            nxt.press_start = 32'd0;
          end
        end
        ST_PRESS: begin
          if (!active) begin
            nxt.fsm = ST_PRESSEND;
          end else if (repeat_age >= 32'(cfg.repeat_ms)) begin
            ev              = EV_LREPEAT;
            nxt.repeat_time = poll.now_ms;
          end
        end
        ST_PRESSEND: begin
          ev              = EV_LSTOP;
          nxt.fsm         = ST_IDLE;
          nxt.count       = 7'd0;
          nxt.press_start = 32'd0;
        end
        default: begin
          nxt.fsm = ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    res.ev              = ev;
    res.click_count     = nxt.count;
    res.level_known     = nxt.stable_known;
    res.debounced_level = nxt.stable_known & nxt.stable_level;
    res.is_idle         = (nxt.fsm == ST_IDLE);
    res.is_long_pressed = (nxt.fsm == ST_PRESS);
    res.pressed_ms      = poll.now_ms - nxt.press_start;
  end

endmodule

### hw/rtl/button_click_press_detector.sv
// Top level of the debounced button click / long press detector.
// Depends on bcpd_pkg and bcpd_step.
//
//  channel  dir  handshake           payload
//  in       in   in_valid/in_stall   raw_level, now_ms, clear
//  out      out  out_valid/out_stall event_res, click_count, level_known,
//                                    debounced_level, is_idle,
//                                    is_long_pressed, pressed_ms
//  cfg      in   cfg_write           cfg_index, cfg_data
//
// One poll per clock while in_stall is low; a poll passes the input register, then the result register.
// The state update and result are formed in one pass through bcpd_step.
// rst clears state and handshake flags and sets the config registers to their defaults.
// in_stall rises only while both the input and result registers are held.
module button_click_press_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        raw_level,
  input  logic [31:0] now_ms,
  input  logic        clear,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_res,
  output logic [6:0]  click_count,
  output logic        level_known,
  output logic        debounced_level,
  output logic        is_idle,
  output logic        is_long_pressed,
  output logic [31:0] pressed_ms,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bcpd_pkg::*;

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  poll_t   s1_poll;
  logic    s1_valid;
  result_t res_next;
  result_t res;
  logic    advance;

  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && out_valid && out_stall;

  bcpd_step u_step (
    .cfg  (cfg),
    .cur  (state),
    .poll (s1_poll),
    .nxt  (state_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_len  <= DEF_DEBOUNCE;
      cfg.click_gap     <= DEF_CLICK;
      cfg.hold_len      <= DEF_PRESS;
      cfg.repeat_ms     <= DEF_REPEAT;
      cfg.pressed_level <= DEF_PRESSED_LVL;
      cfg.click_limit   <= DEF_CLICK_LIMIT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEBOUNCE:    cfg.debounce_len  <= cfg_data;
        REG_CLICK:       cfg.click_gap     <= cfg_data;
        REG_PRESS:       cfg.hold_len      <= cfg_data;
        REG_REPEAT:      cfg.repeat_ms     <= cfg_data;
        REG_PRESSED_LVL: cfg.pressed_level <= cfg_data[0];
        REG_CLICK_LIMIT: cfg.click_limit   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_poll.raw_level <= raw_level;
      s1_poll.now_ms    <= now_ms;
      s1_poll.clear     <= clear;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.fsm          <= ST_IDLE;
      state.count        <= 7'd0;
      state.press_start  <= 32'd0;
      state.repeat_time  <= 32'd0;
      state.settle_time  <= 32'd0;
      state.raw_known    <= 1'b0;
      state.last_raw     <= 1'b0;
      state.stable_known <= 1'b0;
      state.stable_level <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign event_res       = res.ev;
  assign click_count     = res.click_count;
  assign level_known     = res.level_known;
  assign debounced_level = res.debounced_level;
  assign is_idle         = res.is_idle;
  assign is_long_pressed = res.is_long_pressed;
  assign pressed_ms      = res.pressed_ms;

endmodule

### hw/rtl/bcpd_checker.sv
// Port-level checks for the button press detector, bound to the top level.
// Depends on bcpd_pkg and button_click_press_detector_macros.svh.
`include "button_click_press_detector_macros.svh"

module bcpd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  event_res,
  input logic [6:0]  click_count,
  input logic        level_known,
  input logic        debounced_level,
  input logic        is_idle,
  input logic        is_long_pressed
);
  import bcpd_pkg::*;

  // held result must not move
  `BCPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(event_res) && $stable(click_count), "result changed while stalled")

  // a finished sequence lands back in idle with the count cleared
  `BCPD_ASSERT_NOW(a_seq_end_idle, out_valid && (event_res == EV_CLICK || event_res == EV_DOUBLE || event_res == EV_MULTI || event_res == EV_LSTOP), is_idle && (click_count == 7'd0), "sequence end not idle")

  `BCPD_ASSERT_NOW(a_lstart_state, out_valid && (event_res == EV_LSTART), is_long_pressed && !is_idle, "long start outside long press")

  // without a settled level the machine cannot leave idle
  `BCPD_ASSERT_NOW(a_unknown_idle, out_valid && !level_known, is_idle && !debounced_level, "activity before level known")

endmodule

bind button_click_press_detector bcpd_checker u_bcpd_checker (.*);
